[sv/grp_pkg.sv]
// ----------------------------------------------------------------------------
// Grid rectangle placement package
// Shared widths, field codes and cell values for the occupancy grid block.
// ----------------------------------------------------------------------------
`default_nettype none

package grp_pkg;

   // Grid store size. MAX_COLS must stay a power of two: the cell address is
   // the row and column concatenated.
   localparam int ROW_W    = 6;
   localparam int COL_W    = 6;
   localparam int MAX_ROWS = 64;
   localparam int MAX_COLS = 64;
   localparam int ADDR_W   = ROW_W + COL_W;
   localparam int DEPTH    = MAX_ROWS * MAX_COLS;

   // Field widths.
   localparam int OP_W     = 2;
   localparam int CELL_W   = 2;
   localparam int SIZE_W   = 7;
   localparam int STATUS_W = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;

   // Width used for bounds arithmetic (row + height fits, and so does MAX_ROWS).
   localparam int DIM_W = 9;

   typedef logic [OP_W-1:0]     opcode_type;
   typedef logic [CELL_W-1:0]   cell_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [ADDR_W-1:0]   addr_type;

   localparam opcode_type OP_WRITE = 2'd0;
   localparam opcode_type OP_READ  = 2'd1;
   localparam opcode_type OP_PLACE = 2'd2;
   localparam opcode_type OP_NOP   = 2'd3;

   localparam status_type ST_OK      = 2'd0;
   localparam status_type ST_OOB     = 2'd1;
   localparam status_type ST_BLOCKED = 2'd2;
   localparam status_type ST_UNUSED  = 2'd3;

   localparam cell_type CELL_FREE     = 2'd0;
   localparam cell_type CELL_OBSTACLE = 2'd1;
   localparam cell_type CELL_PLACED   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_MAP_ROWS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_COLS = 1'd1;

   localparam logic [CSR_DATA_W-1:0] MAP_ROWS_RESET = 7'd64;
   localparam logic [CSR_DATA_W-1:0] MAP_COLS_RESET = 7'd64;

endpackage

`default_nettype wire

[sv/grp_if.sv]
// ----------------------------------------------------------------------------
// Grid rectangle placement channels
// Request and response channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

interface grp_req_if;
   import grp_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [OP_W-1:0]       opcode;
   logic [ROW_W-1:0]      row;
   logic [COL_W-1:0]      col;
   logic [CELL_W-1:0]     cell_value;
   logic [SIZE_W-1:0]     rect_height;
   logic [SIZE_W-1:0]     rect_width;

   modport source (output valid, opcode, row, col, cell_value, rect_height, rect_width,
                   input ready);
   modport sink   (input valid, opcode, row, col, cell_value, rect_height, rect_width,
                   output ready);
endinterface

interface grp_rsp_if;
   import grp_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [STATUS_W-1:0]   status;
   logic [CELL_W-1:0]     read_value;

   modport source (output valid, status, read_value, input ready);
   modport sink   (input valid, status, read_value, output ready);
endinterface

`default_nettype wire

[sv/grid_rectangle_place.sv]
// ----------------------------------------------------------------------------
// Grid rectangle placement
// Occupancy grid of 2-bit cells with cell access and rectangle placement.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req_bus (valid/ready), each giving exactly one beat on
//   rsp_bus with status and read_value. The map size is to be set through the
//   csr_ write port while the block is idle; the block does not enforce this.
//   Flow: one request is worked on at a time, against a grid RAM with a
//   registered read. A cell write, an out-of-bounds request, an empty
//   rectangle or opcode three goes from acceptance to S_RESULT, which loads
//   the response register; a cell read passes through S_READ first. A
//   placement of h rows by w columns issues one RAM read per cell to look
//   for obstacles, checks each cell as its data returns, then makes one RAM
//   write per cell to fill. A blocked placement stops as soon as the first
//   obstacle is seen. After the response is registered, the block returns
//   to S_IDLE to take the next request.
//   Reset: the map size returns to 64 x 64 and the grid is swept to free,
//   one cell per cycle, over all 4096 cells; req_bus.ready stays low meanwhile,
//   while csr_ writes are taken as usual.
//   Stall: a finished response waits in the output register while rsp_bus
//   is stalled; the next request may already be accepted, and its response
//   waits until the register empties.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_rectangle_place (
   input  wire logic                          clock,
   input  wire logic                          reset,
   grp_req_if.sink                            req_bus,
   grp_rsp_if.source                          rsp_bus,
   input  wire logic                          csr_we,
   input  wire logic [grp_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [grp_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import grp_pkg::*;

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_READ   = 3'd2;
   localparam logic [2:0] S_SCAN   = 3'd3;
   localparam logic [2:0] S_FILL   = 3'd4;
   localparam logic [2:0] S_RESULT = 3'd5;

   logic [2:0]             state_ff, state_in;
   addr_type               clr_addr_ff, clr_addr_in;
   logic [ROW_W-1:0]       cur_r_ff, cur_r_in, row0_ff, row0_in, last_r_ff, last_r_in;
   logic [COL_W-1:0]       cur_c_ff, cur_c_in, col0_ff, col0_in, last_c_ff, last_c_in;
   logic                   chk_valid_ff, chk_valid_in;
   logic                   issue_done_ff, issue_done_in;
   status_type             pend_status_ff, pend_status_in;
   cell_type               pend_read_ff, pend_read_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             rsp_status_ff, rsp_status_in;
   cell_type               rsp_read_ff, rsp_read_in;
   logic [CSR_DATA_W-1:0]  map_rows_ff, map_cols_ff;

   logic                   mem_we;
   addr_type               mem_waddr, mem_raddr;
   cell_type               mem_wdata, mem_rdata;

   logic [DIM_W-1:0]       used_rows, used_cols;
   logic [DIM_W-1:0]       row_ext, col_ext, h_ext, w_ext;
   logic [DIM_W-1:0]       end_r, end_c;
   logic                   cell_oob, rect_oob, rect_empty;
   logic                   accept, last_cell;
   addr_type               cur_addr;

   grp_ram #(
      .WIDTH (CELL_W),
      .DEPTH (DEPTH)
   ) u_grid (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // A map size above the store acts as the store size.
   assign used_rows = (DIM_W'(map_rows_ff) > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS)
                                                               : DIM_W'(map_rows_ff);
   assign used_cols = (DIM_W'(map_cols_ff) > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS)
                                                               : DIM_W'(map_cols_ff);

   assign row_ext = DIM_W'(req_bus.row);
   assign col_ext = DIM_W'(req_bus.col);
   assign h_ext   = DIM_W'(req_bus.rect_height);
   assign w_ext   = DIM_W'(req_bus.rect_width);
   assign end_r   = row_ext + h_ext;
   assign end_c   = col_ext + w_ext;

   assign cell_oob   = (row_ext >= used_rows) || (col_ext >= used_cols);
   assign rect_oob   = (end_r > used_rows) || (end_c > used_cols);
   assign rect_empty = (req_bus.rect_height == '0) || (req_bus.rect_width == '0);

   assign req_bus.ready = (state_ff == S_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;

   assign cur_addr  = {cur_r_ff, cur_c_ff};
   assign last_cell = (cur_r_ff == last_r_ff) && (cur_c_ff == last_c_ff);

   always_comb begin
      state_in       = state_ff;
      clr_addr_in    = clr_addr_ff;
      cur_r_in       = cur_r_ff;
      cur_c_in       = cur_c_ff;
      row0_in        = row0_ff;
      col0_in        = col0_ff;
      last_r_in      = last_r_ff;
      last_c_in      = last_c_ff;
      chk_valid_in   = chk_valid_ff;
      issue_done_in  = issue_done_ff;
      pend_status_in = pend_status_ff;
      pend_read_in   = pend_read_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_read_in    = rsp_read_ff;
      mem_we         = 1'b0;
      mem_waddr      = cur_addr;
      mem_wdata      = CELL_FREE;
      mem_raddr      = cur_addr;

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_CLEAR: begin
            mem_we      = 1'b1;
            mem_waddr   = clr_addr_ff;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == addr_type'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            mem_raddr = {req_bus.row, req_bus.col};
            if (accept) begin
               pend_status_in = ST_OK;
               pend_read_in   = CELL_FREE;
               state_in       = S_RESULT;
               unique case (req_bus.opcode)
                  OP_WRITE: begin
                     if (cell_oob) begin
                        pend_status_in = ST_OOB;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = {req_bus.row, req_bus.col};
                        mem_wdata = req_bus.cell_value;
                     end
                  end
                  OP_READ: begin
                     if (cell_oob) begin
                        pend_status_in = ST_OOB;
                     end else begin
                        state_in = S_READ;
                     end
                  end
                  OP_PLACE: begin
                     // Bounds come first; an empty rectangle in bounds succeeds.
                     if (rect_oob) begin
                        pend_status_in = ST_OOB;
                     end else if (!rect_empty) begin
                        cur_r_in      = req_bus.row;
                        cur_c_in      = req_bus.col;
                        row0_in       = req_bus.row;
                        col0_in       = req_bus.col;
                        last_r_in     = ROW_W'(end_r - 1'b1);
                        last_c_in     = COL_W'(end_c - 1'b1);
                        chk_valid_in  = 1'b0;
                        issue_done_in = 1'b0;
                        state_in      = S_SCAN;
                     end
                  end
                  OP_NOP: begin
                     pend_status_in = ST_OK;
                  end
                  default: begin
                     pend_status_in = ST_OK;
                  end
               endcase
            end
         end
         S_READ: begin
            pend_read_in = mem_rdata;
            state_in     = S_RESULT;
         end
         S_SCAN: begin
            // Reads are issued one cell per cycle; each cell is checked in the
            // following cycle, when its data returns.
            if (chk_valid_ff && (mem_rdata == CELL_OBSTACLE)) begin
               pend_status_in = ST_BLOCKED;
               state_in       = S_RESULT;
            end else if (issue_done_ff) begin
               cur_r_in = row0_ff;
               cur_c_in = col0_ff;
               state_in = S_FILL;
            end else begin
               chk_valid_in = 1'b1;
               if (last_cell) begin
                  issue_done_in = 1'b1;
               end else if (cur_c_ff == last_c_ff) begin
                  cur_c_in = col0_ff;
                  cur_r_in = cur_r_ff + 1'b1;
               end else begin
                  cur_c_in = cur_c_ff + 1'b1;
               end
            end
         end
         S_FILL: begin
            mem_we    = 1'b1;
            mem_wdata = CELL_PLACED;
            if (last_cell) begin
               state_in = S_RESULT;
            end else if (cur_c_ff == last_c_ff) begin
               cur_c_in = col0_ff;
               cur_r_in = cur_r_ff + 1'b1;
            end else begin
               cur_c_in = cur_c_ff + 1'b1;
            end
         end
         S_RESULT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pend_status_ff;
               rsp_read_in   = pend_read_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_r_ff       <= cur_r_in;
      cur_c_ff       <= cur_c_in;
      row0_ff        <= row0_in;
      col0_ff        <= col0_in;
      last_r_ff      <= last_r_in;
      last_c_ff      <= last_c_in;
      chk_valid_ff   <= chk_valid_in;
      issue_done_ff  <= issue_done_in;
      pend_status_ff <= pend_status_in;
      pend_read_ff   <= pend_read_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_read_ff    <= rsp_read_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_rows_ff <= MAP_ROWS_RESET;
         map_cols_ff <= MAP_COLS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MAP_ROWS: map_rows_ff <= csr_wdata;
            CSR_MAP_COLS: map_cols_ff <= csr_wdata;
            default: begin
               map_rows_ff <= map_rows_ff;
            end
         endcase
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.status     = rsp_status_ff;
   assign rsp_bus.read_value = rsp_read_ff;

endmodule

`default_nettype wire

[sv/grp_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module grp_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[sv/grp_check.sv]
// ----------------------------------------------------------------------------
// Grid rectangle placement checker
// Port-level properties of the block, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module grp_check (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_valid,
   input wire logic                         req_ready,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire logic [grp_pkg::STATUS_W-1:0] rsp_status,
   input wire logic [grp_pkg::CELL_W-1:0]   rsp_read_value
);
   import grp_pkg::*;

   // The grid is swept after reset, so no request can be taken right away.
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request taken during the clearing sweep");

   // Items are worked one at a time: acceptance is never back to back.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted in consecutive cycles");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status != ST_UNUSED))
      else $error("undefined status code on the response");

   // Only a successful read returns a cell value.
   a_read_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_OK)) |-> (rsp_read_value == CELL_FREE))
      else $error("read value nonzero on a refused request");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_status) && $stable(rsp_read_value)))
      else $error("response changed while stalled");

endmodule

bind grid_rectangle_place grp_check u_grp_check (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_status     (rsp_bus.status),
   .rsp_read_value (rsp_bus.read_value)
);

`default_nettype wire

[tb/tb_grid_rectangle_place.sv]
// ----------------------------------------------------------------------------
// Grid rectangle placement testbench
// Drives cell writes, cell reads and rectangle placements under several map
// sizes, with random gaps on both channels, and checks every response beat
// against a typed expectation or a cycle-free model of the grid kept inside the bench.
// ----------------------------------------------------------------------------
module tb_grid_rectangle_place;
   import grp_pkg::*;

   localparam int  HOLD_OFF_CYCLES = 300;
   localparam int  WATCHDOG_LIMIT  = 40000;
   localparam int  ITEMS_PER_PHASE = 8;
   localparam int  HOLD_PHASE      = 4;
   localparam bit  TYPED           = 1'b1;
   localparam bit  PREDICTED       = 1'b0;

   typedef struct packed {
      opcode_type        opcode;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      cell_type          cell_value;
      logic [SIZE_W-1:0] rect_height;
      logic [SIZE_W-1:0] rect_width;
   } grid_req_type;

   typedef struct packed {
      status_type status;
      cell_type   read_value;
   } grid_rsp_type;

   typedef struct {
      bit                    set_map;
      logic [CSR_DATA_W-1:0] map_rows;
      logic [CSR_DATA_W-1:0] map_cols;
      grid_req_type          req;
      bit                    typed;
      grid_rsp_type          rsp;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   grp_req_if req_bus();
   grp_rsp_if rsp_bus();

   grid_rectangle_place dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // Shadow of the grid and the map size, updated as beats are accepted and the map is written.
   cell_type              grid_model [MAX_ROWS][MAX_COLS];
   logic [CSR_DATA_W-1:0] model_rows;
   logic [CSR_DATA_W-1:0] model_cols;

   grid_rsp_type expected_rsp_q [$];
   plan_row_type directed_q [$];
   bit           pending_map;
   logic [CSR_DATA_W-1:0] pending_rows;
   logic [CSR_DATA_W-1:0] pending_cols;

   int burst_left;
   bit hold_off_req;
   int mismatch_count;
   int quiet_cycles;

   function automatic int clip_dim(input logic [CSR_DATA_W-1:0] v, input int limit);
      return (v > limit) ? limit : int'(v);
   endfunction

   function automatic grid_rsp_type predict_grid(input grid_req_type it);
      grid_rsp_type res;
      int ur, uc, r, c, h, w, i, j;
      bit hit;
      ur = clip_dim(model_rows, MAX_ROWS);
      uc = clip_dim(model_cols, MAX_COLS);
      r = int'(it.row);
      c = int'(it.col);
      h = int'(it.rect_height);
      w = int'(it.rect_width);
      hit = 1'b0;
      res.status = ST_OK;
      res.read_value = CELL_FREE;
      case (it.opcode)
         OP_WRITE, OP_READ: begin
            if (r >= ur || c >= uc)
               res.status = ST_OOB;
            else if (it.opcode == OP_WRITE)
               grid_model[r][c] = it.cell_value;
            else
               res.read_value = grid_model[r][c];
         end
         OP_PLACE: begin
            // Bounds are tested before the obstacle scan, even for an empty rectangle.
            if (r + h > ur || c + w > uc) begin
               res.status = ST_OOB;
            end else begin
               for (i = r; i < r + h; i++)
                  for (j = c; j < c + w; j++)
                     if (grid_model[i][j] == CELL_OBSTACLE)
                        hit = 1'b1;
               if (hit)
                  res.status = ST_BLOCKED;
               else
                  for (i = r; i < r + h; i++)
                     for (j = c; j < c + w; j++)
                        grid_model[i][j] = CELL_PLACED;
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic grid_req_type random_grid_req();
      grid_req_type it;
      int ur, uc, span_r, span_c, pick;
      ur = clip_dim(model_rows, MAX_ROWS);
      uc = clip_dim(model_cols, MAX_COLS);
      pick = $urandom_range(0, 15);
      if (pick < 5)
         it.opcode = OP_WRITE;
      else if (pick < 9)
         it.opcode = OP_READ;
      else if (pick < 15)
         it.opcode = OP_PLACE;
      else
         it.opcode = OP_NOP;
      // Obstacles are written often so that placements get blocked now and then.
      if ($urandom_range(0, 2) == 0)
         it.cell_value = CELL_OBSTACLE;
      else
         it.cell_value = CELL_W'($urandom_range(0, 3));
      // Accesses are often steered into a small corner of the map so cells get reused.
      if (ur == 0 || uc == 0 || $urandom_range(0, 5) == 0) begin
         it.row = ROW_W'($urandom);
         it.col = COL_W'($urandom);
      end else begin
         span_r = (ur > 8 && $urandom_range(0, 2) != 0) ? 8 : ur;
         span_c = (uc > 8 && $urandom_range(0, 2) != 0) ? 8 : uc;
         it.row = ROW_W'($urandom_range(0, span_r - 1));
         it.col = COL_W'($urandom_range(0, span_c - 1));
      end
      pick = $urandom_range(0, 15);
      if (pick == 0) begin
         it.rect_height = SIZE_W'($urandom);
         it.rect_width  = SIZE_W'($urandom);
      end else if (pick == 1 && ur * uc <= 256 && it.row < ur && it.col < uc) begin
         it.rect_height = SIZE_W'(ur - int'(it.row));
         it.rect_width  = SIZE_W'(uc - int'(it.col));
      end else begin
         it.rect_height = SIZE_W'($urandom_range(0, 4));
         it.rect_width  = SIZE_W'($urandom_range(0, 3));
      end
      return it;
   endfunction

   function automatic void plan_map(input logic [CSR_DATA_W-1:0] rows,
                                    input logic [CSR_DATA_W-1:0] cols);
      pending_map  = 1'b1;
      pending_rows = rows;
      pending_cols = cols;
   endfunction

   function automatic void plan_item(input opcode_type op, input int row, input int col,
                                     input cell_type val, input int h, input int w,
                                     input bit typed, input status_type st,
                                     input cell_type rv);
      plan_row_type p;
      p.set_map          = pending_map;
      p.map_rows         = pending_rows;
      p.map_cols         = pending_cols;
      p.req.opcode       = op;
      p.req.row          = ROW_W'(row);
      p.req.col          = COL_W'(col);
      p.req.cell_value   = val;
      p.req.rect_height  = SIZE_W'(h);
      p.req.rect_width   = SIZE_W'(w);
      p.typed            = typed;
      p.rsp.status       = st;
      p.rsp.read_value   = rv;
      directed_q.push_back(p);
      pending_map = 1'b0;
   endfunction

   // Offers one request beat, in bursts with random gaps in between.
   task automatic send_req(input grid_req_type it, input bit typed, input grid_rsp_type want);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 8);
      end
      req_bus.valid       <= 1'b1;
      req_bus.opcode      <= it.opcode;
      req_bus.row         <= it.row;
      req_bus.col         <= it.col;
      req_bus.cell_value  <= it.cell_value;
      req_bus.rect_height <= it.rect_height;
      req_bus.rect_width  <= it.rect_width;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      if (typed) begin
         void'(predict_grid(it));
         expected_rsp_q.push_back(want);
      end else begin
         expected_rsp_q.push_back(predict_grid(it));
      end
      burst_left--;
   endtask

   task automatic drain_responses();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      while (expected_rsp_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_map(input logic [CSR_DATA_W-1:0] rows,
                            input logic [CSR_DATA_W-1:0] cols);
      csr_we    <= 1'b1;
      csr_index <= CSR_MAP_ROWS;
      csr_wdata <= rows;
      @(posedge clock);
      model_rows = rows;
      csr_index <= CSR_MAP_COLS;
      csr_wdata <= cols;
      @(posedge clock);
      model_cols = cols;
      csr_we <= 1'b0;
   endtask

   initial begin : stimulus
      logic [CSR_DATA_W-1:0] phase_rows [9];
      logic [CSR_DATA_W-1:0] phase_cols [9];
      grid_rsp_type no_rsp;
      phase_rows = '{7'd64, 7'd1, 7'd64, 7'd1, 7'd8, 7'd0, 7'd0, 7'd127, 7'd3};
      phase_cols = '{7'd64, 7'd1, 7'd1, 7'd64, 7'd8, 7'd0, 7'd37, 7'd100, 7'd127};
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.opcode      <= OP_NOP;
      req_bus.row         <= '0;
      req_bus.col         <= '0;
      req_bus.cell_value  <= CELL_FREE;
      req_bus.rect_height <= '0;
      req_bus.rect_width  <= '0;
      csr_we              <= 1'b0;
      csr_index           <= CSR_MAP_ROWS;
      csr_wdata           <= '0;
      no_rsp = '0;
      burst_left = 0;
      hold_off_req = 1'b0;
      pending_map = 1'b0;
      model_rows = MAP_ROWS_RESET;
      model_cols = MAP_COLS_RESET;
      foreach (grid_model[r, c])
         grid_model[r][c] = CELL_FREE;

      // Fresh grid, full 64 x 64 map.
      plan_item(OP_READ,   0,  0, CELL_FREE,     0,   0, TYPED, ST_OK, CELL_FREE);
      plan_item(OP_READ,  63, 63, CELL_FREE,     0,   0, TYPED, ST_OK, CELL_FREE);
      plan_item(OP_WRITE,  0,  0, 2'd3,          0,   0, TYPED, ST_OK, CELL_FREE);
      plan_item(OP_READ,   0,  0, CELL_FREE,     0,   0, PREDICTED, ST_OK, CELL_FREE);
      plan_item(OP_WRITE, 63, 63, CELL_OBSTACLE, 0,   0, TYPED, ST_OK, CELL_FREE);
      plan_item(OP_PLACE,  0,  0, CELL_FREE,     0,   0, TYPED, ST_OK, CELL_FREE);
      plan_item(OP_PLACE, 63, 63, CELL_FREE,     1,   1, TYPED, ST_BLOCKED, CELL_FREE);
      plan_item(OP_PLACE,  0,  0, CELL_FREE,    64,  64, TYPED, ST_BLOCKED, CELL_FREE);
      plan_item(OP_PLACE,  0,  1, CELL_FREE,    64,  64, TYPED, ST_OOB, CELL_FREE);
      plan_item(OP_PLACE, 63,  0, CELL_FREE,     2,   0, TYPED, ST_OOB, CELL_FREE);
      plan_item(OP_PLACE,  0,  0, CELL_FREE,     0, 127, TYPED, ST_OOB, CELL_FREE);
      plan_item(OP_NOP,   63, 63, 2'd3,        127, 127, TYPED, ST_OK, CELL_FREE);
      plan_item(OP_WRITE, 63, 63, CELL_FREE,     0,   0, TYPED, ST_OK, CELL_FREE);
      // Full-map fill, which also overwrites the non-blocking value at the corner.
      plan_item(OP_PLACE,  0,  0, CELL_FREE,    64,  64, PREDICTED, ST_OK, CELL_FREE);
      plan_item(OP_READ,   0,  0, CELL_FREE,     0,   0, PREDICTED, ST_OK, CELL_FREE);
      plan_item(OP_WRITE,  5,  7, CELL_OBSTACLE, 0,   0, TYPED, ST_OK, CELL_FREE);
      plan_item(OP_PLACE,  4,  6, CELL_FREE,     2,   2, TYPED, ST_BLOCKED, CELL_FREE);
      plan_map(7'd5, 7'd9);
      plan_item(OP_WRITE,  5,  0, CELL_PLACED,   0,   0, TYPED, ST_OOB, CELL_FREE);
      plan_item(OP_READ,   0,  9, CELL_FREE,     0,   0, TYPED, ST_OOB, CELL_FREE);
      plan_item(OP_PLACE,  0,  0, CELL_FREE,     5,   9, PREDICTED, ST_OK, CELL_FREE);
      plan_map(7'd0, 7'd0);
      plan_item(OP_READ,   0,  0, CELL_FREE,     0,   0, TYPED, ST_OOB, CELL_FREE);
      plan_item(OP_PLACE,  0,  0, CELL_FREE,     0,   0, TYPED, ST_OK, CELL_FREE);
      plan_map(7'd127, 7'd100);
      plan_item(OP_READ,  63, 63, CELL_FREE,     0,   0, PREDICTED, ST_OK, CELL_FREE);
      plan_item(OP_PLACE, 60, 60, CELL_FREE,     4,   4, PREDICTED, ST_OK, CELL_FREE);
      plan_item(OP_PLACE, 61,  0, CELL_FREE,     4,   1, TYPED, ST_OOB, CELL_FREE);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_q[i]) begin
         if (directed_q[i].set_map) begin
            drain_responses();
            write_map(directed_q[i].map_rows, directed_q[i].map_cols);
         end
         send_req(directed_q[i].req, directed_q[i].typed, directed_q[i].rsp);
      end

      for (int p = 0; p < 9; p++) begin
         drain_responses();
         if (p == 5)
            write_map(CSR_DATA_W'($urandom_range(1, 64)), CSR_DATA_W'($urandom_range(1, 64)));
         else
            write_map(phase_rows[p], phase_cols[p]);
         // In this phase the receiver holds off long enough for the input to back up.
         if (p == HOLD_PHASE) begin
            hold_off_req = 1'b1;
            wait (!hold_off_req);
         end
         repeat (ITEMS_PER_PHASE)
            send_req(random_grid_req(), PREDICTED, no_rsp);
      end

      drain_responses();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin : rsp_stall_pattern
      int run;
      int gap;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         run = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
         rsp_bus.ready <= 1'b1;
         repeat (run) @(posedge clock);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      grid_rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_rsp_q.size() == 0) begin
            $error("unexpected response beat: status %0d read_value %0d",
                   rsp_bus.status, rsp_bus.read_value);
            mismatch_count++;
         end else begin
            want = expected_rsp_q.pop_front();
            if (rsp_bus.status !== want.status) begin
               $error("status mismatch: expected %0d, got %0d", want.status, rsp_bus.status);
               mismatch_count++;
            end
            if (rsp_bus.read_value !== want.read_value) begin
               $error("read_value mismatch: expected %0d, got %0d",
                      want.read_value, rsp_bus.read_value);
               mismatch_count++;
            end
         end
      end
   end

   // Ends a hung run: counts cycles in which neither channel moves a beat.
   always @(posedge clock) begin : watchdog
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

endmodule

[filelist.f]
sv/grp_pkg.sv
sv/grp_if.sv
sv/grp_ram.sv
sv/grid_rectangle_place.sv
sv/grp_check.sv
tb/tb_grid_rectangle_place.sv
